### hdl/assert_macros.svh
// Assertion macros for the RTL files; fsct_dp.sv is the one that includes them.
// Each use must sit in a module that has i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, ignored while reset is held.
`define FSCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define FSCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/fsct_pkg.sv
package fsct_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NEG  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_OOB  = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic [30:0] frame;
        logic [7:0]  chan;
        logic [15:0] key;
        logic [63:0] value;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT,
        ST_WRITE,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        RES_INS_OK,
        RES_NEG,
        RES_FULL,
        RES_OOB,
        RES_READ
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic srch_init;
        logic srch_rd;
        logic srch_step;
        logic pos_zero;
        logic pos_cnt;
        logic shift_init;
        logic shift_step;
        logic ins_write;
        logic rd_issue;
        logic out_load;
        t_res res;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic neg;
        logic full;
        logic empty;
        logic append;
        logic oob;
        logic srch_eq;
        logic srch_close;
        logic shift_last;
        logic out_free;
    } t_dp_sts;

endpackage

### hdl/fsct_if.sv
interface fsct_cmd_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] frame;
    logic        [7:0]  chan;
    logic        [15:0] setting_key;
    logic        [63:0] setting_value;
    logic        [7:0]  read_index;

    modport source (
        output valid, op, frame, chan, setting_key, setting_value, read_index,
        input  ready
    );
    modport sink (
        input  valid, op, frame, chan, setting_key, setting_value, read_index,
        output ready
    );
endinterface

interface fsct_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  position;
    logic [30:0] entry_frame;
    logic [7:0]  entry_chan;
    logic [15:0] entry_key;
    logic [63:0] entry_value;
    logic [8:0]  entry_count;
    logic [30:0] last_frame;

    modport source (
        output valid, status, position, entry_frame, entry_chan, entry_key,
               entry_value, entry_count, last_frame,
        input  ready
    );
    modport sink (
        input  valid, status, position, entry_frame, entry_chan, entry_key,
               entry_value, entry_count, last_frame,
        output ready
    );
endinterface

### hdl/fsct_ctrl.sv
module fsct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fsct_pkg::t_dp_sts i_sts,
    output fsct_pkg::t_dp_cmd o_cmd
);

    fsct_pkg::t_state r_state, n_state;
    fsct_pkg::t_res   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsct_pkg::ST_IDLE;
            r_res   <= fsct_pkg::RES_INS_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        o_cmd      = '0;
        o_cmd.res  = r_res;
        o_in_ready = 1'b0;
        case (r_state)
            fsct_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = fsct_pkg::ST_DECODE;
                end
            end
            fsct_pkg::ST_DECODE: begin
                if (i_sts.is_read) begin
                    if (i_sts.oob) begin
                        n_res   = fsct_pkg::RES_OOB;
                        n_state = fsct_pkg::ST_DONE;
                    end else begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = fsct_pkg::ST_READ_WAIT;
                    end
                end else if (i_sts.neg) begin
                    n_res   = fsct_pkg::RES_NEG;
                    n_state = fsct_pkg::ST_DONE;
                end else if (i_sts.full) begin
                    n_res   = fsct_pkg::RES_FULL;
                    n_state = fsct_pkg::ST_DONE;
                end else if (i_sts.empty) begin
                    o_cmd.pos_zero = 1'b1;
                    n_state        = fsct_pkg::ST_WRITE;
                end else if (i_sts.append) begin
                    o_cmd.pos_cnt = 1'b1;
                    n_state       = fsct_pkg::ST_WRITE;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = fsct_pkg::ST_SRCH_RD;
                end
            end
            fsct_pkg::ST_SRCH_RD: begin
                o_cmd.srch_rd = 1'b1;
                n_state       = fsct_pkg::ST_SRCH_CMP;
            end
            fsct_pkg::ST_SRCH_CMP: begin
                o_cmd.srch_step = 1'b1;
                if (i_sts.srch_eq || i_sts.srch_close) begin
                    n_state = fsct_pkg::ST_SHIFT_RD;
                end else begin
                    n_state = fsct_pkg::ST_SRCH_RD;
                end
            end
            fsct_pkg::ST_SHIFT_RD: begin
                o_cmd.shift_init = 1'b1;
                n_state          = fsct_pkg::ST_SHIFT;
            end
            fsct_pkg::ST_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_sts.shift_last) begin
                    n_state = fsct_pkg::ST_WRITE;
                end
            end
            fsct_pkg::ST_WRITE: begin
                o_cmd.ins_write = 1'b1;
                n_res           = fsct_pkg::RES_INS_OK;
                n_state         = fsct_pkg::ST_DONE;
            end
            fsct_pkg::ST_READ_WAIT: begin
                n_res   = fsct_pkg::RES_READ;
                n_state = fsct_pkg::ST_DONE;
            end
            fsct_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = fsct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fsct_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/fsct_dp.sv
`include "assert_macros.svh"

module fsct_dp #(
    parameter int TABLE_DEPTH = fsct_pkg::TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fsct_pkg::t_dp_cmd  i_cmd,
    output fsct_pkg::t_dp_sts  o_sts,
    input  logic               i_op,
    input  logic signed [31:0] i_frame,
    input  logic        [7:0]  i_chan,
    input  logic        [15:0] i_setting_key,
    input  logic        [63:0] i_setting_value,
    input  logic        [7:0]  i_read_index,
    fsct_res_if.source         o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    fsct_pkg::t_entry r_mem [TABLE_DEPTH];
    fsct_pkg::t_entry r_rd_data;

    logic          r_op;
    logic [31:0]   r_frame;
    logic [7:0]    r_chan;
    logic [15:0]   r_key;
    logic [63:0]   r_value;
    logic [7:0]    r_ridx;
    logic [CW-1:0] r_count;
    logic [30:0]   r_last;
    logic [CW-1:0] r_lo, r_hi;
    logic [AW-1:0] r_mid, r_pos, r_dst;
    logic          r_out_valid;

    logic [CW:0]     w_mid_sum;
    logic [CW-1:0]   w_mid_x, w_mid_p1, w_lo_nx, w_hi_nx;
    logic [30:0]     w_frame_lo;
    logic            w_lt, w_gt;
    logic [CW+7:0]   w_ridx_x, w_cnt_x;
    logic [AW+7:0]   w_pos_x;
    logic            w_rd_en, w_wr_en;
    logic [AW-1:0]   w_rd_addr, w_wr_addr;
    fsct_pkg::t_entry w_wr_data;

    assign w_frame_lo = r_frame[30:0];
    assign w_mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid_x    = CW'(r_mid);
    assign w_mid_p1   = w_mid_x + CW'(1);
    assign w_lt       = w_frame_lo < r_rd_data.frame;
    assign w_gt       = w_frame_lo > r_rd_data.frame;
    assign w_lo_nx    = w_gt ? w_mid_p1 : r_lo;
    assign w_hi_nx    = w_lt ? w_mid_x : r_hi;
    assign w_ridx_x   = {{CW{1'b0}}, r_ridx};
    assign w_cnt_x    = {8'd0, r_count};
    assign w_pos_x    = {8'd0, r_pos};

    always_comb begin
        o_sts            = '0;
        o_sts.is_read    = (r_op == fsct_pkg::OP_READ);
        o_sts.neg        = r_frame[31];
        o_sts.full       = (r_count == CW'(TABLE_DEPTH));
        o_sts.empty      = (r_count == '0);
        o_sts.append     = (w_frame_lo >= r_last);
        o_sts.oob        = (w_ridx_x >= w_cnt_x);
        o_sts.srch_eq    = !w_lt && !w_gt;
        o_sts.srch_close = (w_lo_nx >= w_hi_nx);
        o_sts.shift_last = ((r_dst - AW'(1)) == r_pos);
        o_sts.out_free   = !r_out_valid || o_res.ready;
    end

    // One read and one write port; the shift reads two below while writing.
    always_comb begin
        w_rd_en = i_cmd.srch_rd || i_cmd.shift_init || i_cmd.shift_step || i_cmd.rd_issue;
        if (i_cmd.srch_rd) begin
            w_rd_addr = w_mid_sum[AW:1];
        end else if (i_cmd.shift_init) begin
            w_rd_addr = AW'(r_count - CW'(1));
        end else if (i_cmd.shift_step) begin
            w_rd_addr = r_dst - AW'(2);
        end else begin
            w_rd_addr = w_ridx_x[AW-1:0];
        end
        w_wr_en = i_cmd.shift_step || i_cmd.ins_write;
        if (i_cmd.shift_step) begin
            w_wr_addr = r_dst;
            w_wr_data = r_rd_data;
        end else begin
            w_wr_addr = r_pos;
            w_wr_data = '{frame: w_frame_lo, chan: r_chan, key: r_key, value: r_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_frame <= i_frame;
            r_chan  <= i_chan;
            r_key   <= i_setting_key;
            r_value <= i_setting_value;
            r_ridx  <= i_read_index;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end
        if (i_cmd.srch_rd) begin
            r_mid <= w_mid_sum[AW:1];
        end
        if (i_cmd.srch_step) begin
            r_lo  <= w_lo_nx;
            r_hi  <= w_hi_nx;
            r_pos <= o_sts.srch_eq ? r_mid : w_lo_nx[AW-1:0];
        end
        if (i_cmd.pos_zero) begin
            r_pos <= '0;
        end
        if (i_cmd.pos_cnt) begin
            r_pos <= AW'(r_count);
        end
        if (i_cmd.shift_init) begin
            r_dst <= AW'(r_count);
        end
        if (i_cmd.shift_step) begin
            r_dst <= r_dst - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= '0;
        end else if (i_cmd.ins_write) begin
            r_count <= r_count + CW'(1);
            if (CW'(r_pos) == r_count) begin
                r_last <= w_frame_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_res.entry_frame <= '0;
            o_res.entry_chan  <= '0;
            o_res.entry_key   <= '0;
            o_res.entry_value <= '0;
            o_res.entry_count <= w_cnt_x[8:0];
            o_res.last_frame  <= r_last;
            case (i_cmd.res)
                fsct_pkg::RES_INS_OK: begin
                    o_res.status   <= fsct_pkg::STAT_OK;
                    o_res.position <= w_pos_x[7:0];
                end
                fsct_pkg::RES_NEG: begin
                    o_res.status   <= fsct_pkg::STAT_NEG;
                    o_res.position <= '0;
                end
                fsct_pkg::RES_FULL: begin
                    o_res.status   <= fsct_pkg::STAT_FULL;
                    o_res.position <= '0;
                end
                fsct_pkg::RES_OOB: begin
                    o_res.status   <= fsct_pkg::STAT_OOB;
                    o_res.position <= r_ridx;
                end
                fsct_pkg::RES_READ: begin
                    o_res.status      <= fsct_pkg::STAT_OK;
                    o_res.position    <= r_ridx;
                    o_res.entry_frame <= r_rd_data.frame;
                    o_res.entry_chan  <= r_rd_data.chan;
                    o_res.entry_key   <= r_rd_data.key;
                    o_res.entry_value <= r_rd_data.value;
                end
                default: begin
                    o_res.status   <= fsct_pkg::STAT_OK;
                    o_res.position <= '0;
                end
            endcase
        end
    end

    assign o_res.valid = r_out_valid;

    `FSCT_ASSERT(a_count_bound, r_count <= CW'(TABLE_DEPTH), "entry count beyond table depth")
    `FSCT_ASSERT(a_ins_count, i_cmd.ins_write |=> r_count == $past(r_count) + CW'(1), "count slip")
    `FSCT_ASSERT(a_out_hold, i_cmd.out_load |-> !r_out_valid || o_res.ready, "result overrun")
    `FSCT_ASSERT(a_shift_range, i_cmd.shift_step |-> r_pos < r_dst, "shift below insert slot")

endmodule

### hdl/frame_sorted_command_table.sv
// Frame-sorted command table: holds up to TABLE_DEPTH timed commands (frame, channel,
// key, 64-bit value pattern) in ascending frame order in one single-port-read,
// single-port-write memory. Each beat on i_cmd yields exactly one beat on o_res.
// An insert with a negative frame, or into a full table, leaves the table alone and
// reports status; otherwise the slot is 0 for an empty table, the end when the frame
// is at or above the last one, else found by binary search over the memory (each step
// one read and one compare). Entries at and above the slot then move up one per
// cycle, the new entry is written, and the result is loaded. A search takes at most
// floor(log2(count)) + 1 steps. A read goes from decode through a memory read to the
// result; an append or an insert into an empty table goes from decode to the write;
// a rejected insert or a read beyond the count goes from decode to the result. The
// result waits while the output register still holds one not yet taken. One item is
// in flight at a time; the next beat is taken while the previous result still waits
// in the output register. Every result carries the entry count and the last frame
// (0 when empty).
// No clearing pass runs after reset: only entries below the count are ever used.

module frame_sorted_command_table #(
    parameter int TABLE_DEPTH = fsct_pkg::TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsct_cmd_if.sink   i_cmd,
    fsct_res_if.source o_res
);

    // Command and status between sequencer and datapath.
    fsct_pkg::t_dp_cmd w_cmd;
    fsct_pkg::t_dp_sts w_sts;

    // Sequencer: accept a beat, decide the path, step the search and the move.
    fsct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: item registers, table memory, search bounds, output register.
    fsct_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_op            (i_cmd.op),
        .i_frame         (i_cmd.frame),
        .i_chan          (i_cmd.chan),
        .i_setting_key   (i_cmd.setting_key),
        .i_setting_value (i_cmd.setting_value),
        .i_read_index    (i_cmd.read_index),
        .o_res           (o_res)
    );

endmodule
